>>> rtl/urf_pkg.sv
`timescale 1ns / 1ps

package urf_pkg;

   // Timing of the echo conversion
   localparam int TICKS_PER_US = 42;
   localparam int US_PER_CM    = 58;
   localparam int TICKS_PER_CM = TICKS_PER_US * US_PER_CM;
   localparam int WINDOW       = 10;

   // Field widths
   localparam int PERIOD_W = 23;
   localparam int WIDTH_W  = 12;
   localparam int DIST_W   = 11;
   localparam int GOOD_W   = 5;
   localparam int WDIST_W  = 12;
   localparam int CSR_W    = 23;
   localparam int CSR_IDX_W = 3;

   localparam int DIST_MAX = (1 << DIST_W) - 1;

   // Sub-centimeter tick counter and the per-window decomposition of a distance
   localparam int SUB_W  = (TICKS_PER_CM > 1) ? $clog2(TICKS_PER_CM) : 1;
   localparam int RES_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CMQ_W  = $clog2(DIST_MAX / WINDOW + 1);
   localparam int FILL_W = $clog2(WINDOW + 1);

   // Reset values of the configuration registers
   localparam logic [PERIOD_W-1:0] TRIGGER_PERIOD_RST = PERIOD_W'(4200000);
   localparam logic [WIDTH_W-1:0]  TRIGGER_WIDTH_RST  = WIDTH_W'(378);
   localparam logic [DIST_W-1:0]   MIN_DISTANCE_RST   = DIST_W'(2);
   localparam logic [DIST_W-1:0]   MAX_DISTANCE_RST   = DIST_W'(50);
   localparam logic [GOOD_W-1:0]   MIN_GOOD_COUNT_RST = GOOD_W'(7);

   localparam logic signed [WDIST_W-1:0] WDIST_INVALID = -12'sd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIGGER_PERIOD = 3'd0,
      CSR_TRIGGER_WIDTH  = 3'd1,
      CSR_MIN_DISTANCE   = 3'd2,
      CSR_MAX_DISTANCE   = 3'd3,
      CSR_MIN_GOOD_COUNT = 3'd4
   } csr_index_type;

endpackage

>>> rtl/ultrasonic_range_filter.sv
`timescale 1ns / 1ps
// Ultrasonic echo ranging with a windowed average filter.
// Latency: the result transaction for a tick is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle as long as each result is taken; the output register
// lets a tick be accepted while the previous result is taken in the same cycle.
// Reset (synchronous, active high) clears all counters and loads the default
// configuration (10 Hz trigger at 42 MHz, 378-tick pulse, good band 3..49 cm, over 7 good).

module ultrasonic_range_filter import urf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // tick input
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_echo,
   // result output
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_trigger,
   output logic                      rsp_distance_valid,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic                      rsp_window_valid,
   output logic signed [WDIST_W-1:0] rsp_window_distance,
   // configuration writes
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [PERIOD_W-1:0] trigger_period_ff;
   logic [WIDTH_W-1:0]  trigger_width_ff;
   logic [DIST_W-1:0]   min_distance_ff;
   logic [DIST_W-1:0]   max_distance_ff;
   logic [GOOD_W-1:0]   min_good_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_period_ff <= TRIGGER_PERIOD_RST;
         trigger_width_ff  <= TRIGGER_WIDTH_RST;
         min_distance_ff   <= MIN_DISTANCE_RST;
         max_distance_ff   <= MAX_DISTANCE_RST;
         min_good_count_ff <= MIN_GOOD_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TRIGGER_PERIOD: trigger_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_TRIGGER_WIDTH:  trigger_width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_MIN_DISTANCE:   min_distance_ff   <= csr_wdata[DIST_W-1:0];
            CSR_MAX_DISTANCE:   max_distance_ff   <= csr_wdata[DIST_W-1:0];
            CSR_MIN_GOOD_COUNT: min_good_count_ff <= csr_wdata[GOOD_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Tick state
   // The echo length is kept directly in centimeters: a sub counter wraps
   // every TICKS_PER_CM ticks and bumps the cm count, which saturates at
   // DIST_MAX. The cm count is also held as quotient/residue by WINDOW, and
   // the window sum the same way, so the window average is the sum quotient
   // and no divider is needed.
   // ---------------------------------------------------------------------
   logic [PERIOD_W-1:0] period_count_ff, period_count_in;
   logic [WIDTH_W-1:0]  pulse_count_ff,  pulse_count_in;
   logic                echo_prev_ff,    echo_prev_in;
   logic                measuring_ff,    measuring_in;
   logic [SUB_W-1:0]    sub_count_ff,    sub_count_in;
   logic [DIST_W-1:0]   cm_ff,           cm_in;
   logic [CMQ_W-1:0]    cm_q_ff,         cm_q_in;
   logic [RES_W-1:0]    cm_r_ff,         cm_r_in;
   logic [DIST_W-1:0]   last_distance_ff, last_distance_in;
   logic [FILL_W-1:0]   window_fill_ff,  window_fill_in;
   logic [DIST_W-1:0]   sum_q_ff,        sum_q_in;
   logic [RES_W-1:0]    sum_r_ff,        sum_r_in;
   logic [FILL_W-1:0]   good_count_ff,   good_count_in;

   // result register
   logic                      rsp_valid_ff;
   logic                      trigger_ff,         trigger_in;
   logic                      distance_valid_ff,  distance_valid_in;
   logic                      window_valid_ff,    window_valid_in;
   logic signed [WDIST_W-1:0] window_distance_ff, window_distance_in;

   logic                accept;
   logic [PERIOD_W:0]   period_next;
   logic [RES_W:0]      sum_r_add;
   logic [DIST_W-1:0]   sum_q_add;
   logic [FILL_W-1:0]   fill_add;
   logic [FILL_W-1:0]   good_add;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      period_count_in    = period_count_ff;
      pulse_count_in     = pulse_count_ff;
      echo_prev_in       = req_echo;
      measuring_in       = measuring_ff;
      sub_count_in       = sub_count_ff;
      cm_in              = cm_ff;
      cm_q_in            = cm_q_ff;
      cm_r_in            = cm_r_ff;
      last_distance_in   = last_distance_ff;
      window_fill_in     = window_fill_ff;
      sum_q_in           = sum_q_ff;
      sum_r_in           = sum_r_ff;
      good_count_in      = good_count_ff;
      distance_valid_in  = 1'b0;
      window_valid_in    = 1'b0;
      window_distance_in = '0;
      sum_r_add          = '0;
      sum_q_add          = '0;
      fill_add           = '0;
      good_add           = '0;

      // trigger: high while the pulse counter is nonzero; a period wrap
      // reloads the pulse, which then starts on the next tick
      trigger_in = (pulse_count_ff != '0);
      if (pulse_count_ff != '0) begin
         pulse_count_in = pulse_count_ff - WIDTH_W'(1);
      end
      period_next = {1'b0, period_count_ff} + (PERIOD_W+1)'(1);
      if (period_next >= {1'b0, trigger_period_ff}) begin
         period_count_in = '0;
         pulse_count_in  = trigger_width_ff;
      end else begin
         period_count_in = period_next[PERIOD_W-1:0];
      end

      // echo measurement
      if (req_echo && !echo_prev_ff) begin
         // rising edge counts as the first tick
         measuring_in = 1'b1;
         sub_count_in = SUB_W'(1);
         cm_in        = '0;
         cm_q_in      = '0;
         cm_r_in      = '0;
      end else if (req_echo && measuring_ff) begin
         if (sub_count_ff == SUB_W'(TICKS_PER_CM - 1)) begin
            sub_count_in = '0;
            if (cm_ff != DIST_W'(DIST_MAX)) begin
               cm_in = cm_ff + DIST_W'(1);
               if (cm_r_ff == RES_W'(WINDOW - 1)) begin
                  cm_r_in = '0;
                  cm_q_in = cm_q_ff + CMQ_W'(1);
               end else begin
                  cm_r_in = cm_r_ff + RES_W'(1);
               end
            end
         end else begin
            sub_count_in = sub_count_ff + SUB_W'(1);
         end
      end else if (!req_echo && echo_prev_ff && measuring_ff) begin
         // falling edge: distance complete
         measuring_in      = 1'b0;
         last_distance_in  = cm_ff;
         distance_valid_in = 1'b1;

         sum_r_add = {1'b0, sum_r_ff} + {1'b0, cm_r_ff};
         sum_q_add = sum_q_ff + DIST_W'(cm_q_ff);
         if (sum_r_add >= (RES_W+1)'(WINDOW)) begin
            sum_r_add = sum_r_add - (RES_W+1)'(WINDOW);
            sum_q_add = sum_q_add + DIST_W'(1);
         end
         good_add = good_count_ff;
         if (cm_ff > min_distance_ff && cm_ff < max_distance_ff) begin
            good_add = good_count_ff + FILL_W'(1);
         end
         fill_add = window_fill_ff + FILL_W'(1);

         if (fill_add >= FILL_W'(WINDOW)) begin
            window_valid_in = 1'b1;
            if (GOOD_W'(good_add) > min_good_count_ff) begin
               window_distance_in = WDIST_W'(sum_q_add);
            end else begin
               window_distance_in = WDIST_INVALID;
            end
            window_fill_in = '0;
            sum_q_in       = '0;
            sum_r_in       = '0;
            good_count_in  = '0;
         end else begin
            window_fill_in = fill_add;
            sum_q_in       = sum_q_add;
            sum_r_in       = sum_r_add[RES_W-1:0];
            good_count_in  = good_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff  <= '0;
         pulse_count_ff   <= '0;
         echo_prev_ff     <= 1'b0;
         measuring_ff     <= 1'b0;
         sub_count_ff     <= '0;
         cm_ff            <= '0;
         cm_q_ff          <= '0;
         cm_r_ff          <= '0;
         last_distance_ff <= '0;
         window_fill_ff   <= '0;
         sum_q_ff         <= '0;
         sum_r_ff         <= '0;
         good_count_ff    <= '0;
      end else if (accept) begin
         period_count_ff  <= period_count_in;
         pulse_count_ff   <= pulse_count_in;
         echo_prev_ff     <= echo_prev_in;
         measuring_ff     <= measuring_in;
         sub_count_ff     <= sub_count_in;
         cm_ff            <= cm_in;
         cm_q_ff          <= cm_q_in;
         cm_r_ff          <= cm_r_in;
         last_distance_ff <= last_distance_in;
         window_fill_ff   <= window_fill_in;
         sum_q_ff         <= sum_q_in;
         sum_r_ff         <= sum_r_in;
         good_count_ff    <= good_count_in;
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload; the raw distance comes straight from last_distance_ff
   always_ff @(posedge clock) begin
      if (accept) begin
         trigger_ff         <= trigger_in;
         distance_valid_ff  <= distance_valid_in;
         window_valid_ff    <= window_valid_in;
         window_distance_ff <= window_distance_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_trigger         = trigger_ff;
   assign rsp_distance_valid  = distance_valid_ff;
   assign rsp_distance        = last_distance_ff;
   assign rsp_window_valid    = window_valid_ff;
   assign rsp_window_distance = window_distance_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_window_needs_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && window_valid_ff |-> distance_valid_ff)
      else $error("window result without a completed distance");

   a_cm_split: assert property (@(posedge clock) disable iff (reset)
      (cm_r_ff < RES_W'(WINDOW)) &&
      (cm_ff == DIST_W'(cm_q_ff) * DIST_W'(WINDOW) + DIST_W'(cm_r_ff)))
      else $error("cm quotient/residue out of step");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (window_fill_ff < FILL_W'(WINDOW)) && (good_count_ff <= window_fill_ff))
      else $error("window fill or good count out of range");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("input stalled with an empty output register");

   a_no_edge_no_distance: assert property (@(posedge clock) disable iff (reset)
      accept && !(echo_prev_ff && !req_echo) |=> !distance_valid_ff)
      else $error("distance reported without a falling echo edge");

endmodule
